### src/dll_pkg.sv
package dll_pkg;

   // Store geometry
   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LINK_W   = $clog2(CAPACITY + 1);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Field widths of the request and response
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   // A link equal to the capacity means there is no node.
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CAPACITY);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_FIND       = 3'd2,
      OP_REMOVE     = 3'd3,
      OP_DUMP       = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_NOT_FOUND   = 2'd2,
      ST_NOT_IN_USE  = 2'd3
   } status_type;

   // One response as it is held in the output register.
   typedef struct packed {
      status_type                 status;
      logic [SLOT_W-1:0]          found_slot;
      logic signed [VALUE_W-1:0]  item_value;
      logic [COUNT_W-1:0]         count;
      logic                       is_empty;
      logic                       item_valid;
      logic                       last;
   } rsp_type;

   // Access to the node store: one read port, one write port per field.
   typedef struct packed {
      logic                       rd_en;
      logic [ADDR_W-1:0]          rd_addr;
      logic                       val_we;
      logic [ADDR_W-1:0]          val_addr;
      logic signed [VALUE_W-1:0]  val_data;
      logic                       nxt_we;
      logic [ADDR_W-1:0]          nxt_addr;
      logic [LINK_W-1:0]          nxt_data;
      logic                       prv_we;
      logic [ADDR_W-1:0]          prv_addr;
      logic [LINK_W-1:0]          prv_data;
   } mem_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  val;
      logic [LINK_W-1:0]          nxt;
      logic [LINK_W-1:0]          prv;
   } mem_rsp_type;

endpackage

### src/dll_req_if.sv
interface dll_req_if import dll_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic signed [VALUE_W-1:0]  value;
   logic [SLOT_W-1:0]          slot;

   modport source (output valid, op, value, slot, input ready);
   modport sink (input valid, op, value, slot, output ready);
endinterface

### src/dll_rsp_if.sv
interface dll_rsp_if import dll_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic [SLOT_W-1:0]          found_slot;
   logic signed [VALUE_W-1:0]  item_value;
   logic [COUNT_W-1:0]         count;
   logic                       is_empty;
   logic                       item_valid;
   logic                       last;

   modport source (output valid, status, found_slot, item_value, count, is_empty,
                   item_valid, last, input ready);
   modport sink (input valid, status, found_slot, item_value, count, is_empty,
                 item_valid, last, output ready);
endinterface

### src/dll_node_mem.sv
module dll_node_mem import dll_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output mem_rsp_type mem_rsp
);

   logic signed [VALUE_W-1:0] value_mem [CAPACITY];
   logic [LINK_W-1:0]         next_mem  [CAPACITY];
   logic [LINK_W-1:0]         prev_mem  [CAPACITY];

   // Writes, one port per field so a node and a neighbor can be updated together.
   always_ff @(posedge clock) begin
      if (mem_req.val_we) begin
         value_mem[mem_req.val_addr] <= mem_req.val_data;
      end
      if (mem_req.nxt_we) begin
         next_mem[mem_req.nxt_addr] <= mem_req.nxt_data;
      end
      if (mem_req.prv_we) begin
         prev_mem[mem_req.prv_addr] <= mem_req.prv_data;
      end
   end

   // Registered read; the data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         mem_rsp.val <= value_mem[mem_req.rd_addr];
         mem_rsp.nxt <= next_mem[mem_req.rd_addr];
         mem_rsp.prv <= prev_mem[mem_req.rd_addr];
      end
   end

endmodule

### src/dll_rsp_buf.sv
module dll_rsp_buf import dll_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      emit_valid,
   input  rsp_type   emit_data,
   output logic      out_free,
   dll_rsp_if.source rsp
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The register can take a new response when empty or when drained this cycle.
   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         data_ff <= emit_data;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.status     = data_ff.status;
   assign rsp.found_slot = data_ff.found_slot;
   assign rsp.item_value = data_ff.item_value;
   assign rsp.count      = data_ff.count;
   assign rsp.is_empty   = data_ff.is_empty;
   assign rsp.item_valid = data_ff.item_valid;
   assign rsp.last       = data_ff.last;

endmodule

### src/dll_ctrl.sv
module dll_ctrl import dll_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dll_req_if.sink     req,
   input  logic        out_free,
   output logic        emit_valid,
   output rsp_type     emit_data,
   output mem_req_type mem_req,
   input  mem_rsp_type mem_rsp
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LINK   = 5'b00010,
      S_UNLINK = 5'b00100,
      S_WALK   = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [LINK_W-1:0]         head_ff, head_in;
   logic [LINK_W-1:0]         tail_ff, tail_in;
   logic [CAPACITY-1:0]       in_use_ff, in_use_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   op_type                    op_ff, op_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [ADDR_W-1:0]         cur_ff, cur_in;
   status_type                pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]         pend_slot_ff, pend_slot_in;

   logic [ADDR_W-1:0]         free_slot;
   logic                      full;
   logic [LINK_W-1:0]         cur_link;

   assign req.ready = (state_ff == S_IDLE);
   assign cur_link  = LINK_W'(cur_ff);

   // Lowest free slot from the occupancy bits.
   always_comb begin
      free_slot = '0;
      full      = 1'b1;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_slot = ADDR_W'(i);
            full      = 1'b0;
         end
      end
   end

   // Sequencer: decode, node store updates and list walks.
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      in_use_in      = in_use_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      cur_in         = cur_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      mem_req        = '0;
      emit_valid     = 1'b0;

      emit_data            = '0;
      emit_data.status     = ST_OK;
      emit_data.count      = count_ff;
      emit_data.is_empty   = (count_ff == '0);
      emit_data.last       = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in          = op_type'(req.op);
               value_in       = req.value;
               pend_status_in = ST_OK;
               pend_slot_in   = '0;
               case (op_type'(req.op))
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (full) begin
                        pend_status_in = ST_FULL;
                        state_in       = S_EMIT;
                     end else begin
                        // Write the new node; neighbors are fixed up next cycle.
                        mem_req.val_we   = 1'b1;
                        mem_req.val_addr = free_slot;
                        mem_req.val_data = req.value;
                        mem_req.nxt_we   = 1'b1;
                        mem_req.nxt_addr = free_slot;
                        mem_req.prv_we   = 1'b1;
                        mem_req.prv_addr = free_slot;
                        if (op_type'(req.op) == OP_PUSH_FRONT) begin
                           mem_req.nxt_data = head_ff;
                           mem_req.prv_data = LINK_NONE;
                        end else begin
                           mem_req.nxt_data = LINK_NONE;
                           mem_req.prv_data = tail_ff;
                        end
                        cur_in   = free_slot;
                        state_in = S_LINK;
                     end
                  end
                  OP_FIND, OP_DUMP: begin
                     if (head_ff == LINK_NONE) begin
                        pend_status_in = (op_type'(req.op) == OP_FIND) ? ST_NOT_FOUND
                                                                       : ST_OK;
                        state_in       = S_EMIT;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = head_ff[ADDR_W-1:0];
                        cur_in          = head_ff[ADDR_W-1:0];
                        state_in        = S_WALK;
                     end
                  end
                  OP_REMOVE: begin
                     if (!in_use_ff[ADDR_W'(req.slot)]) begin
                        pend_status_in = ST_NOT_IN_USE;
                        state_in       = S_EMIT;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ADDR_W'(req.slot);
                        cur_in          = ADDR_W'(req.slot);
                        state_in        = S_UNLINK;
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_LINK: begin
            // Hook the new node into its neighbor or the head/tail pointer.
            if (op_ff == OP_PUSH_FRONT) begin
               if (head_ff != LINK_NONE) begin
                  mem_req.prv_we   = 1'b1;
                  mem_req.prv_addr = head_ff[ADDR_W-1:0];
                  mem_req.prv_data = cur_link;
               end else begin
                  tail_in = cur_link;
               end
               head_in = cur_link;
            end else begin
               if (tail_ff != LINK_NONE) begin
                  mem_req.nxt_we   = 1'b1;
                  mem_req.nxt_addr = tail_ff[ADDR_W-1:0];
                  mem_req.nxt_data = cur_link;
               end else begin
                  head_in = cur_link;
               end
               tail_in = cur_link;
            end
            in_use_in[cur_ff] = 1'b1;
            count_in          = count_ff + COUNT_W'(1);
            pend_status_in    = ST_OK;
            pend_slot_in      = SLOT_W'(cur_ff);
            state_in          = S_EMIT;
         end

         S_UNLINK: begin
            // Links of the removed node are on the read port now.
            if (mem_rsp.prv == LINK_NONE) begin
               head_in = mem_rsp.nxt;
            end else begin
               mem_req.nxt_we   = 1'b1;
               mem_req.nxt_addr = mem_rsp.prv[ADDR_W-1:0];
               mem_req.nxt_data = mem_rsp.nxt;
            end
            if (mem_rsp.nxt == LINK_NONE) begin
               tail_in = mem_rsp.prv;
            end else begin
               mem_req.prv_we   = 1'b1;
               mem_req.prv_addr = mem_rsp.nxt[ADDR_W-1:0];
               mem_req.prv_data = mem_rsp.prv;
            end
            in_use_in[cur_ff] = 1'b0;
            count_in          = count_ff - COUNT_W'(1);
            pend_status_in    = ST_OK;
            pend_slot_in      = '0;
            state_in          = S_EMIT;
         end

         S_WALK: begin
            if (op_ff == OP_FIND) begin
               // Compare the current node, then follow its next link.
               if (mem_rsp.val == value_ff) begin
                  pend_status_in = ST_OK;
                  pend_slot_in   = SLOT_W'(cur_ff);
                  state_in       = S_EMIT;
               end else if (mem_rsp.nxt == LINK_NONE) begin
                  pend_status_in = ST_NOT_FOUND;
                  pend_slot_in   = '0;
                  state_in       = S_EMIT;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = mem_rsp.nxt[ADDR_W-1:0];
                  cur_in          = mem_rsp.nxt[ADDR_W-1:0];
               end
            end else if (out_free) begin
               // Dump: one response per node; a stalled output holds the walk.
               emit_valid           = 1'b1;
               emit_data.item_value = mem_rsp.val;
               emit_data.item_valid = 1'b1;
               emit_data.last       = (mem_rsp.nxt == LINK_NONE);
               if (mem_rsp.nxt == LINK_NONE) begin
                  state_in = S_IDLE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = mem_rsp.nxt[ADDR_W-1:0];
                  cur_in          = mem_rsp.nxt[ADDR_W-1:0];
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               emit_valid           = 1'b1;
               emit_data.status     = pend_status_ff;
               emit_data.found_slot = pend_slot_ff;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= LINK_NONE;
         tail_ff   <= LINK_NONE;
         in_use_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         in_use_ff <= in_use_in;
         count_ff  <= count_in;
      end
   end

   // Request fields and walk position.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      value_ff       <= value_in;
      cur_ff         <= cur_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
   end

endmodule

### src/doubly_linked_list_engine.sv
// Push and remove: the request goes from idle through the link or unlink state to the
// emit state; error, empty-list and undefined requests go from idle straight to emit.
// Find: the walk reads one node per cycle until a hit or a miss, then emits; dump:
// one value per cycle behind the first read while the output takes it, then idle.
// One request at a time; a stalled response holds the sequencer. Synchronous reset
// empties the list (head, tail, occupancy, count); the node store is not cleared.
module doubly_linked_list_engine import dll_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dll_req_if.sink   req_ch,
   dll_rsp_if.source rsp_ch
);

   logic        out_free;
   logic        emit_valid;
   rsp_type     emit_data;
   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   dll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .mem_req    (mem_req),
      .mem_rsp    (mem_rsp)
   );

   dll_node_mem u_node_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   dll_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .out_free   (out_free),
      .rsp        (rsp_ch)
   );

endmodule
